>>> hdl/assert_macros.svh
// Assertion helpers shared by the modules of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside of reset.
`define AST_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen outside of reset.
`define AST_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

>>> hdl/sosc_pkg.sv
package sosc_pkg;

    // Field widths.
    localparam int CHAN_W     = 3;
    localparam int PCT_W      = 16;
    localparam int PERIOD_W   = 20;
    localparam int OVR_W      = 17;
    localparam int CLK_W      = 48;
    localparam int POL_W      = 2;
    localparam int ACT_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 120;

    // Fixed point constants.
    localparam int Q_SHIFT = 16;
    localparam logic [OVR_W-1:0] ONE_Q16 = 17'h10000;
    localparam int PROD_RND = 32768;

    // Percent conversion: (p * 65536 + 50) / 100 by reciprocal multiply.
    localparam int PCT_BITS    = 7;
    localparam int PCT_MAX     = 100;
    localparam int PCT_RND     = 50;
    localparam int PCT_NUM_W   = PCT_BITS + Q_SHIFT;
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

    localparam int ACT_RESET = 2;

    typedef enum logic [POL_W-1:0] {
        POL_PRODUCT = 2'd0,
        POL_MINIMUM = 2'd1,
        POL_MAXIMUM = 2'd2,
        POL_AVERAGE = 2'd3
    } t_policy;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 1'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_COMBINE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH,
        ST_TICK_MUL,
        ST_TICK_ADD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load_item;
        logic store_chan;
        logic acc_step;
        logic div_start;
        logic finish;
        logic tick_mul;
        logic tick_add;
    } t_dp_cmd;

    typedef struct packed {
        logic last_chan;
        logic is_avg;
        logic div_done;
    } t_dp_status;

endpackage

>>> hdl/sosc_div.sv
`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle.
module sosc_div #(
    parameter int DVD_W = 20,
    parameter int DVS_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_count;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_quo;

    logic [DVS_W:0]   w_trial;
    logic [DVS_W:0]   w_diff;
    logic             w_fits;
    logic [DVS_W-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[DVD_W-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        w_fits  = (w_trial >= {1'b0, r_dvs});
        n_rem   = w_fits ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= '0;
            end else if (r_busy) begin
                r_count <= r_count + CNT_W'(1);
                if (r_count == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DVD_W-2:0], w_fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    `AST_NEVER(a_start_while_busy, i_clk, i_rst_n, i_start && r_busy, "divider restarted while busy")

endmodule

>>> hdl/sosc_dp.sv
`include "assert_macros.svh"

// Datapath: channel overrides, combining accumulator, clocks.
module sosc_dp #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sosc_pkg::t_dp_cmd                i_cmd,
    output sosc_pkg::t_dp_status             o_status,
    input  sosc_pkg::t_policy                i_policy,
    input  logic [sosc_pkg::ACT_W-1:0]       i_active,
    input  logic [sosc_pkg::CHAN_W-1:0]      i_channel,
    input  logic signed [sosc_pkg::PCT_W-1:0] i_percent,
    input  logic [sosc_pkg::PERIOD_W-1:0]    i_period,
    output logic [sosc_pkg::OVR_W-1:0]       o_combined_ovr,
    output logic [sosc_pkg::CLK_W-1:0]       o_scaled_clk,
    output logic [sosc_pkg::CLK_W-1:0]       o_plain_time
);

    localparam int OVR_W = sosc_pkg::OVR_W;
    localparam int CLK_W = sosc_pkg::CLK_W;
    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
    localparam int DIV_W = sosc_pkg::Q_SHIFT + $clog2(MAX_CHANNELS + 1);
    localparam int INC_W = sosc_pkg::PERIOD_W + OVR_W - sosc_pkg::Q_SHIFT;
    localparam int MUL_W = sosc_pkg::PCT_NUM_W + sosc_pkg::RECIP_W;

    logic [OVR_W-1:0] r_ovr [MAX_CHANNELS];
    logic [OVR_W-1:0] r_combined;
    logic [CLK_W-1:0] r_scaled;
    logic [CLK_W-1:0] r_plain;

    logic [sosc_pkg::CHAN_W-1:0]      r_chan;
    logic signed [sosc_pkg::PCT_W-1:0] r_pct;
    logic [sosc_pkg::PERIOD_W-1:0]    r_period;
    logic [DIV_W-1:0]                 r_acc;
    logic [IDX_W-1:0]                 r_idx;
    logic [INC_W-1:0]                 r_inc;

    logic [CNT_W-1:0]                 w_n;
    logic [sosc_pkg::PCT_BITS-1:0]    w_pct;
    logic [sosc_pkg::PCT_NUM_W-1:0]   w_pct_num;
    logic [MUL_W-1:0]                 w_q_prod;
    logic [OVR_W-1:0]                 w_q;
    logic                             w_chan_ok;
    logic [OVR_W-1:0]                 w_ovr_rd;
    logic [2*OVR_W-1:0]               w_prod;
    logic [2*OVR_W:0]                 w_prod_rnd;
    logic [DIV_W-1:0]                 n_acc;
    logic [DIV_W-1:0]                 n_acc_init;
    logic [DIV_W-1:0]                 w_fin;
    logic [OVR_W+sosc_pkg::PERIOD_W-1:0] w_tick_prod;
    logic [DIV_W-1:0]                 w_dividend;
    logic                             w_div_done;
    logic [DIV_W-1:0]                 w_quotient;

    // Active channel count, with zero taken as one and large values limited.
    always_comb begin
        if (i_active == '0) begin
            w_n = CNT_W'(1);
        end else if (32'(i_active) > MAX_CHANNELS) begin
            w_n = CNT_W'(MAX_CHANNELS);
        end else begin
            w_n = CNT_W'(i_active);
        end
    end

    // Clamp the percent to 0..100 and convert it to Q16 with rounding.
    always_comb begin
        if (r_pct[sosc_pkg::PCT_W-1]) begin
            w_pct = '0;
        end else if (r_pct[sosc_pkg::PCT_W-2:0] > (sosc_pkg::PCT_W-1)'(sosc_pkg::PCT_MAX)) begin
            w_pct = sosc_pkg::PCT_BITS'(sosc_pkg::PCT_MAX);
        end else begin
            w_pct = r_pct[sosc_pkg::PCT_BITS-1:0];
        end
        w_pct_num = {w_pct, sosc_pkg::Q_SHIFT'(0)}
                  + sosc_pkg::PCT_NUM_W'(sosc_pkg::PCT_RND);
        w_q_prod  = MUL_W'(w_pct_num) * MUL_W'(sosc_pkg::RECIP_100);
        w_q       = w_q_prod[sosc_pkg::RECIP_SHIFT +: OVR_W];
        w_chan_ok = (32'(r_chan) < MAX_CHANNELS);
    end

    // One combining step per cycle over the channel at r_idx.
    always_comb begin
        w_ovr_rd   = r_ovr[r_idx];
        w_prod     = r_acc[OVR_W-1:0] * w_ovr_rd;
        w_prod_rnd = {1'b0, w_prod} + (2*OVR_W+1)'(sosc_pkg::PROD_RND);
        case (i_policy)
            sosc_pkg::POL_PRODUCT: begin
                n_acc      = DIV_W'(w_prod_rnd[2*OVR_W:sosc_pkg::Q_SHIFT]);
                n_acc_init = DIV_W'(sosc_pkg::ONE_Q16);
            end
            sosc_pkg::POL_MINIMUM: begin
                n_acc      = (DIV_W'(w_ovr_rd) < r_acc) ? DIV_W'(w_ovr_rd) : r_acc;
                n_acc_init = DIV_W'(sosc_pkg::ONE_Q16);
            end
            sosc_pkg::POL_MAXIMUM: begin
                n_acc      = (DIV_W'(w_ovr_rd) > r_acc) ? DIV_W'(w_ovr_rd) : r_acc;
                n_acc_init = '0;
            end
            default: begin
                n_acc      = r_acc + DIV_W'(w_ovr_rd);
                n_acc_init = '0;
            end
        endcase
        w_dividend  = r_acc + DIV_W'(w_n >> 1);
        w_fin       = (i_policy == sosc_pkg::POL_AVERAGE) ? w_quotient : r_acc;
        w_tick_prod = r_period * r_combined;
    end

    sosc_div #(
        .DVD_W (DIV_W),
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_n),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_ovr[i] <= sosc_pkg::ONE_Q16;
            end
            r_combined <= sosc_pkg::ONE_Q16;
            r_scaled   <= '0;
            r_plain    <= '0;
        end else begin
            if (i_cmd.store_chan && w_chan_ok) begin
                r_ovr[IDX_W'(r_chan)] <= w_q;
            end
            if (i_cmd.finish) begin
                r_combined <= (w_fin > DIV_W'(sosc_pkg::ONE_Q16)) ?
                              sosc_pkg::ONE_Q16 : w_fin[OVR_W-1:0];
            end
            if (i_cmd.tick_add) begin
                r_scaled <= r_scaled + CLK_W'(r_inc);
                r_plain  <= r_plain + CLK_W'(r_period);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_chan   <= i_channel;
            r_pct    <= i_percent;
            r_period <= i_period;
        end
        if (i_cmd.store_chan) begin
            r_acc <= n_acc_init;
            r_idx <= '0;
        end else if (i_cmd.acc_step) begin
            r_acc <= n_acc;
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_cmd.tick_mul) begin
            r_inc <= w_tick_prod[sosc_pkg::Q_SHIFT +: INC_W];
        end
    end

    assign o_status.last_chan = (32'(r_idx) + 1 == 32'(w_n));
    assign o_status.is_avg    = (i_policy == sosc_pkg::POL_AVERAGE);
    assign o_status.div_done  = w_div_done;

    assign o_combined_ovr = r_combined;
    assign o_scaled_clk   = r_scaled;
    assign o_plain_time   = r_plain;

    `AST_PROP(a_combined_range, i_clk, i_rst_n, r_combined <= sosc_pkg::ONE_Q16, "global override above 1.0")

endmodule

>>> hdl/sosc_ctrl.sv
`include "assert_macros.svh"

// Sequencer: walks one item through the datapath and hands off the result.
module sosc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_valid,
    input  logic                 i_tick,
    output logic                 o_s_ready,
    input  logic                 i_out_free,
    output logic                 o_load_out,
    input  sosc_pkg::t_dp_status i_status,
    output sosc_pkg::t_dp_cmd    o_cmd
);

    sosc_pkg::t_state r_state;
    sosc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sosc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_ready  = 1'b0;
        o_load_out = 1'b0;
        case (r_state)
            sosc_pkg::ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = (i_tick == sosc_pkg::CMD_TICK) ?
                              sosc_pkg::ST_TICK_MUL : sosc_pkg::ST_CONVERT;
                end
            end
            sosc_pkg::ST_CONVERT: begin
                o_cmd.store_chan = 1'b1;
                n_state = sosc_pkg::ST_COMBINE;
            end
            sosc_pkg::ST_COMBINE: begin
                o_cmd.acc_step = 1'b1;
                if (i_status.last_chan) begin
                    n_state = i_status.is_avg ? sosc_pkg::ST_DIV_START : sosc_pkg::ST_FINISH;
                end
            end
            sosc_pkg::ST_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state = sosc_pkg::ST_DIV_WAIT;
            end
            sosc_pkg::ST_DIV_WAIT: begin
                if (i_status.div_done) begin
                    n_state = sosc_pkg::ST_FINISH;
                end
            end
            sosc_pkg::ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = sosc_pkg::ST_DONE;
            end
            sosc_pkg::ST_TICK_MUL: begin
                o_cmd.tick_mul = 1'b1;
                n_state = sosc_pkg::ST_TICK_ADD;
            end
            sosc_pkg::ST_TICK_ADD: begin
                o_cmd.tick_add = 1'b1;
                n_state = sosc_pkg::ST_DONE;
            end
            sosc_pkg::ST_DONE: begin
                if (i_out_free) begin
                    o_load_out = 1'b1;
                    n_state = sosc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sosc_pkg::ST_IDLE;
            end
        endcase
    end

    `AST_PROP(a_div_done_in_wait, i_clk, i_rst_n, i_status.div_done |-> (r_state == sosc_pkg::ST_DIV_WAIT), "divider finished outside its wait state")

endmodule

>>> hdl/speed_override_scaled_clock.sv
// Speed-override combiner with a scaled time base. Each override sample
// clamps its signed percent to 0..100, converts it to Q16 (65536 = 1.0,
// halves rounded up), stores it for its channel and recombines the first
// active_channels channels by product, minimum, maximum or rounded average
// into the global override; each tick adds its period to the plain clock
// and (period * global override) >> 16 to the scaled clock, both wrapping
// at 48 bits. Every item yields exactly one result carrying the global
// override and both clocks. Items are handled one at a time: a tick runs
// a multiply step and then an add step, a sample under product, minimum or
// maximum takes one combining step per active channel (through the shared
// multiplier and comparator), and a sample under the average policy also
// runs the rounded mean through a serial divider that produces one quotient
// bit per cycle. A finished result waits in the output register, so the
// next item can be accepted while it is still unclaimed. Configuration
// registers must be written only while no item is in flight, and a new
// policy or channel count shows in the global override from the next
// override sample on.
module speed_override_scaled_clock #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [sosc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sosc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Input items.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata from bit 0 up: channel[2:0], percent[18:3], period[38:19], zero pad.
    input  logic [sosc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser: command (0 override sample, 1 time tick).
    input  logic                                s_axis_tuser,
    // Result items.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata from bit 0 up: combined override[16:0], scaled clock[64:17],
    // plain clock[112:65], zero pad.
    output logic [sosc_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int CHAN_W   = sosc_pkg::CHAN_W;
    localparam int PCT_W    = sosc_pkg::PCT_W;
    localparam int PERIOD_W = sosc_pkg::PERIOD_W;
    localparam int RES_W    = sosc_pkg::OVR_W + 2 * sosc_pkg::CLK_W;
    localparam int PAD_W    = sosc_pkg::OUT_DATA_W - RES_W;

    // Configuration registers.
    sosc_pkg::t_policy                r_policy;
    logic [sosc_pkg::ACT_W-1:0]       r_active;

    // Output register.
    logic                             r_out_valid;
    logic [sosc_pkg::OUT_DATA_W-1:0]  r_out_data;

    sosc_pkg::t_dp_cmd                w_cmd;
    sosc_pkg::t_dp_status             w_status;
    logic                             w_out_free;
    logic                             w_load_out;
    logic [sosc_pkg::OVR_W-1:0]       w_global;
    logic [sosc_pkg::CLK_W-1:0]       w_scaled;
    logic [sosc_pkg::CLK_W-1:0]       w_plain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= sosc_pkg::POL_PRODUCT;
            r_active <= sosc_pkg::ACT_W'(sosc_pkg::ACT_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sosc_pkg::REG_POLICY: r_policy <= sosc_pkg::t_policy'(i_cfg_data[sosc_pkg::POL_W-1:0]);
                sosc_pkg::REG_ACTIVE: r_active <= i_cfg_data[sosc_pkg::ACT_W-1:0];
                default: ;
            endcase
        end
    end

    // The result register frees up when it is empty or drained this cycle.
    assign w_out_free = !r_out_valid || m_axis_tready;

    sosc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (s_axis_tvalid),
        .i_tick     (s_axis_tuser),
        .o_s_ready  (s_axis_tready),
        .i_out_free (w_out_free),
        .o_load_out (w_load_out),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    sosc_dp #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_policy       (r_policy),
        .i_active       (r_active),
        .i_channel      (s_axis_tdata[CHAN_W-1:0]),
        .i_percent      (s_axis_tdata[CHAN_W +: PCT_W]),
        .i_period       (s_axis_tdata[CHAN_W+PCT_W +: PERIOD_W]),
        .o_combined_ovr (w_global),
        .o_scaled_clk   (w_scaled),
        .o_plain_time   (w_plain)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= {PAD_W'(0), w_plain, w_scaled, w_global};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `AST_PROP(a_busy_after_accept, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "new item taken while one is in progress")

endmodule

>>> dv/speed_override_scaled_clock_test.sv
`timescale 1ns / 1ps

import sosc_pkg::*;

// One result item of the block, split into its fields.
typedef struct packed {
    logic [CLK_W-1:0] plain_time;
    logic [CLK_W-1:0] scaled_ticks;
    logic [OVR_W-1:0] ovr_q16;
} ovr_reading_t;

// Keeps its own copy of the channel overrides, the blend registers and both
// clocks, works out the reading that each accepted item must produce and
// compares the readings that come out of the block in order.
class override_clock_board;
    logic [OVR_W-1:0] chan_q16[8];
    logic [OVR_W-1:0] blended;
    logic [CLK_W-1:0] scaled_clk;
    logic [CLK_W-1:0] plain_clk;
    t_policy          blend_policy;
    logic [ACT_W-1:0] blend_count;
    ovr_reading_t     due_readings[$];
    int               mismatches;
    int               readings_checked;

    function new();
        foreach (chan_q16[k]) chan_q16[k] = ONE_Q16;
        blended      = ONE_Q16;
        scaled_clk   = '0;
        plain_clk    = '0;
        blend_policy = POL_PRODUCT;
        blend_count  = ACT_W'(ACT_RESET);
        mismatches   = 0;
        readings_checked = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        if (index == REG_POLICY)
            blend_policy = t_policy'(data[POL_W-1:0]);
        else if (index == REG_ACTIVE)
            blend_count = data[ACT_W-1:0];
    endfunction

    // Clamp to 0..100 percent, then scale to Q16 with halves rounded up.
    function logic [OVR_W-1:0] clamp_percent_q16(logic signed [PCT_W-1:0] pct);
        longint unsigned p;
        if (pct < 0)
            p = 0;
        else if (pct > PCT_MAX)
            p = PCT_MAX;
        else
            p = longint'(pct);
        return OVR_W'(((p << Q_SHIFT) + PCT_RND) / PCT_MAX);
    endfunction

    function logic [OVR_W-1:0] blend_channels();
        longint unsigned acc;
        int unsigned     n;
        n = blend_count;
        if (n == 0)
            n = 1;
        if (n > 8)
            n = 8;
        case (blend_policy)
            POL_PRODUCT: begin
                acc = ONE_Q16;
                for (int k = 0; k < n; k++)
                    acc = (acc * chan_q16[k] + PROD_RND) >> Q_SHIFT;
            end
            POL_MINIMUM: begin
                acc = ONE_Q16;
                for (int k = 0; k < n; k++)
                    if (chan_q16[k] < acc)
                        acc = chan_q16[k];
            end
            POL_MAXIMUM: begin
                acc = 0;
                for (int k = 0; k < n; k++)
                    if (chan_q16[k] > acc)
                        acc = chan_q16[k];
            end
            default: begin
                acc = 0;
                for (int k = 0; k < n; k++)
                    acc += chan_q16[k];
                acc = (acc + n / 2) / n;
            end
        endcase
        if (acc > ONE_Q16)
            acc = ONE_Q16;
        return OVR_W'(acc);
    endfunction

    // Called for every accepted item: update the state, queue the reading.
    function void note_item(logic cmd, logic [CHAN_W-1:0] chan,
                            logic signed [PCT_W-1:0] pct, logic [PERIOD_W-1:0] period);
        ovr_reading_t    want;
        longint unsigned step;
        if (cmd == CMD_SAMPLE) begin
            chan_q16[chan] = clamp_percent_q16(pct);
            blended = blend_channels();
        end else begin
            step = (longint'(period) * longint'(blended)) >> Q_SHIFT;
            plain_clk  = plain_clk + CLK_W'(period);
            scaled_clk = scaled_clk + CLK_W'(step);
        end
        want.ovr_q16      = blended;
        want.scaled_ticks = scaled_clk;
        want.plain_time   = plain_clk;
        due_readings.insert(due_readings.size(), want);
    endfunction

    function int pending();
        return due_readings.size();
    endfunction

    task report_mismatch(string what, longint unsigned got, longint unsigned want);
        mismatches++;
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    task check_result(logic [OUT_DATA_W-1:0] data);
        ovr_reading_t want;
        logic [OVR_W-1:0] got_ovr;
        logic [CLK_W-1:0] got_scaled;
        logic [CLK_W-1:0] got_plain;
        got_ovr    = data[OVR_W-1:0];
        got_scaled = data[OVR_W+CLK_W-1:OVR_W];
        got_plain  = data[OVR_W+2*CLK_W-1:OVR_W+CLK_W];
        if (due_readings.size() == 0) begin
            report_mismatch("result with nothing outstanding, override", got_ovr, 0);
        end else begin
            want = due_readings.pop_front();
            readings_checked++;
            if (got_ovr !== want.ovr_q16)
                report_mismatch("combined override", got_ovr, want.ovr_q16);
            if (got_scaled !== want.scaled_ticks)
                report_mismatch("scaled clock", got_scaled, want.scaled_ticks);
            if (got_plain !== want.plain_time)
                report_mismatch("plain_time", got_plain, want.plain_time);
        end
    endtask
endclass

module speed_override_scaled_clock_test;

    // Cycle limit for the whole run; a run that hangs ends at this limit.
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASES        = 14;
    localparam int PHASE_ITEMS   = 48;
    // After this many accepted items the receiver stops taking results for a while.
    localparam int HOLD_AT_ITEM  = 150;
    localparam int HOLD_CYCLES   = 400;
    // Settling wait at the end of a drain, sized for a sample under the average policy with 8 channels.
    localparam int SETTLE_CYCLES = 40;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
    logic                    s_axis_tuser = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;

    override_clock_board board = new();

    int  cycle_count = 0;
    int  items_in = 0;
    int  samples_sent = 0;
    int  ticks_sent = 0;
    int  settings_used = 0;
    // Per-phase switches for random idling on each side.
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;

    speed_override_scaled_clock u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a run that hangs anywhere ends here as a failure.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d readings still outstanding",
                 cycle_count, board.pending());
        $display("speed_override_scaled_clock_test: FAIL");
        $finish;
    end

    // Receiver. Ready changes at the falling edge only. Stalls are mostly
    // short with the odd long one, and once the receiver holds off for a
    // long stretch so that a finished reading sits in the output register and
    // the block has to stop taking items.
    int  rx_busy = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(negedge i_clk) begin
        if (!hold_done && items_in >= HOLD_AT_ITEM) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_busy > 0) begin
            rx_busy--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (rx_idle_on && $urandom_range(0, 99) < 20)
                rx_busy = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3)
                                                     : $urandom_range(10, 40);
        end
    end

    // Every reading taken from the block is checked against the oldest one due.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);
    end

    function int pick_gap();
        int r;
        if (!tx_idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offers one item, waits for the block to take it, then leaves valid high
    // for back-to-back items or drops it for a random gap.
    task send_item(logic cmd, logic [CHAN_W-1:0] chan,
                   logic signed [PCT_W-1:0] pct, logic [PERIOD_W-1:0] period);
        int gap;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{(IN_DATA_W-CHAN_W-PCT_W-PERIOD_W){1'b0}}, period, pct, chan};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        board.note_item(cmd, chan, pct, period);
        items_in++;
        if (cmd == CMD_SAMPLE)
            samples_sent++;
        else
            ticks_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Stops offering items and waits until every reading has come back, then
    // lets the block settle so that a register write finds it idle.
    task drain_block(int patience);
        int waited;
        waited = 0;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0 && waited < patience) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        board.set_register(index, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task apply_setting(t_policy pol, logic [ACT_W-1:0] count);
        write_register(REG_POLICY, CFG_DATA_W'(pol));
        write_register(REG_ACTIVE, CFG_DATA_W'(count));
        settings_used++;
    endtask

    // Random item. Samples mostly land on an active channel with an in-range
    // percent, so that the blend actually moves; the rest push the clamp
    // and the inactive channels.
    task send_random_item(int live);
        logic                    cmd;
        logic [CHAN_W-1:0]       chan;
        logic signed [PCT_W-1:0] pct;
        logic [PERIOD_W-1:0]     period;
        logic [31:0]             bits32;
        int                      r;
        int                      neg;
        cmd = ($urandom_range(0, 99) < 55) ? CMD_SAMPLE : CMD_TICK;
        chan = ($urandom_range(0, 99) < 80) ? CHAN_W'($urandom_range(0, live - 1))
                                            : CHAN_W'($urandom_range(0, 7));
        bits32 = $urandom();
        r = $urandom_range(0, 99);
        neg = -int'($urandom_range(1, 32768));
        if (r < 55)
            pct = PCT_W'($urandom_range(0, PCT_MAX));
        else if (r < 65)
            pct = PCT_W'($urandom_range(PCT_MAX + 1, 32767));
        else if (r < 75)
            pct = neg[PCT_W-1:0];
        else
            pct = bits32[PCT_W-1:0];
        bits32 = $urandom();
        r = $urandom_range(0, 99);
        if (r < 10)
            period = '0;
        else if (r < 20)
            period = '1;
        else if (r < 50)
            period = PERIOD_W'($urandom_range(0, 255));
        else
            period = bits32[PERIOD_W-1:0];
        send_item(cmd, chan, pct, period);
    endtask

    t_policy          phase_pol;
    logic [ACT_W-1:0] phase_count;
    int               live;

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, under the reset setting (product over two channels).
        // Ticks with the shortest and longest period before any sample.
        send_item(CMD_TICK, 3'd0, 16'sd0, 20'd0);
        send_item(CMD_TICK, 3'd5, -16'sd1, 20'hFFFFF);
        // The most negative percent and minus one both clamp to zero.
        send_item(CMD_SAMPLE, 3'd0, 16'sh8000, 20'hFFFFF);
        send_item(CMD_TICK, 3'd0, 16'sd0, 20'd12345);
        send_item(CMD_SAMPLE, 3'd0, -16'sd1, 20'd0);
        // Exactly 100, just above it and the largest positive value.
        send_item(CMD_SAMPLE, 3'd0, 16'sd100, 20'd0);
        send_item(CMD_SAMPLE, 3'd1, 16'sd101, 20'd0);
        send_item(CMD_SAMPLE, 3'd1, 16'sd32767, 20'd0);
        // Values whose conversion needs rounding.
        send_item(CMD_SAMPLE, 3'd0, 16'sd50, 20'd0);
        send_item(CMD_SAMPLE, 3'd1, 16'sd33, 20'd0);
        send_item(CMD_SAMPLE, 3'd0, 16'sd1, 20'd0);
        send_item(CMD_TICK, 3'd7, 16'sh5555, 20'hAAAAA);
        // A sample for an inactive channel still recomputes the blend.
        send_item(CMD_SAMPLE, 3'd7, 16'sd0, 20'h55555);
        send_item(CMD_SAMPLE, 3'd0, 16'sd99, 20'd0);
        send_item(CMD_TICK, 3'd2, 16'sd0, 20'h55555);
        drain_block(20000);

        // A new setting leaves the blended value alone until the next sample.
        apply_setting(POL_MAXIMUM, 4'd8);
        send_item(CMD_TICK, 3'd0, 16'sd0, 20'hFFFFF);
        send_item(CMD_SAMPLE, 3'd6, 16'sd0, 20'd0);
        send_item(CMD_SAMPLE, 3'd2, 16'sh2AAA, 20'd0);
        drain_block(20000);
        apply_setting(POL_AVERAGE, 4'd0);
        send_item(CMD_SAMPLE, 3'd0, 16'sd25, 20'd0);
        send_item(CMD_TICK, 3'd0, 16'sd0, 20'hFFFFF);
        drain_block(20000);

        // Random phases. The first few cover the extremes of both registers,
        // including the out-of-range channel counts, and the rest pick freely.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin phase_pol = POL_PRODUCT; phase_count = 4'd8;  end
                1: begin phase_pol = POL_MINIMUM; phase_count = 4'd1;  end
                2: begin phase_pol = POL_MAXIMUM; phase_count = 4'd8;  end
                3: begin phase_pol = POL_AVERAGE; phase_count = 4'd8;  end
                4: begin phase_pol = POL_AVERAGE; phase_count = 4'd1;  end
                5: begin phase_pol = POL_PRODUCT; phase_count = 4'd0;  end
                6: begin phase_pol = POL_MINIMUM; phase_count = 4'd15; end
                7: begin phase_pol = POL_MAXIMUM; phase_count = 4'd1;  end
                default: begin
                    phase_pol = t_policy'($urandom_range(0, 3));
                    phase_count = ($urandom_range(0, 9) < 8)
                                  ? ACT_W'($urandom_range(1, 8))
                                  : ACT_W'($urandom_range(0, 15));
                end
            endcase
            // Some phases run with no idling at all on one side or both.
            tx_idle_on = (ph % 3) != 1;
            rx_idle_on = (ph % 4) != 2;
            apply_setting(phase_pol, phase_count);
            live = (phase_count == 0) ? 1 : (phase_count > 8) ? 8 : phase_count;
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_random_item(live);
            drain_block(20000);
        end

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (int k = 0; k < board.pending(); k++)
            board.report_mismatch("reading never produced, override",
                                  0, board.due_readings[k].ovr_q16);

        $display("Covered %0d override samples and %0d ticks under %0d register settings,",
                 samples_sent, ticks_sent, settings_used);
        $display("all four blend policies, channel counts 0 to 15; %0d readings checked.",
                 board.readings_checked);
        if (board.mismatches == 0) begin
            $display("speed_override_scaled_clock_test: PASS");
        end else begin
            $display("speed_override_scaled_clock_test: FAIL");
        end
        $finish;
    end

endmodule
